// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the sparse row accumulator.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SRAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define SRAU_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SRAU_ASSERT(label, prop, msg)
`define SRAU_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ===== sv/srau_pkg.sv =====
// Shared types and field widths for the sparse row accumulator update core.
// No dependencies.
`default_nettype none

package srau_pkg;

  // Transaction field widths
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned FEAT_W = 10;
  localparam int unsigned DIM_W  = 6;
  localparam int unsigned BKT_W  = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ACC_EW = 16;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_WR_WEIGHT  = 3'd0,
    REQ_WR_BWEIGHT = 3'd1,
    REQ_WR_ACC     = 3'd2,
    REQ_WR_BACC    = 3'd3,
    REQ_REMOVE     = 3'd4,
    REQ_ADD        = 3'd5,
    REQ_RD_ACC     = 3'd6,
    REQ_RD_BUCKET  = 3'd7
  } req_e;

endpackage

`default_nettype wire

// ===== sv/srau_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module srau_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/sparse_row_accumulator_update_core.sv =====
// Sparse row accumulator update core: weight tables, accumulators, sequencer.
// Depends on srau_pkg, srau_ram and assert_macros.svh.
// Writes finish in the accepting cycle; reads strobe the result in the cycle after acceptance.
// Add/remove hold busy through the accumulator pass, the bucket pass and a drain state,
// using the single shared 32-bit adder and one element per cycle on each RAM port.
// Results cannot be stalled. Reset clears control state only; stores are not cleared.
`default_nettype none
`include "assert_macros.svh"

module sparse_row_accumulator_update_core #(
  parameter int unsigned ACC_WIDTH    = 64,
  parameter int unsigned NUM_BUCKETS  = 8,
  parameter int unsigned NUM_FEATURES = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [srau_pkg::REQ_W-1:0]         req_type_i,
  input  wire logic [srau_pkg::FEAT_W-1:0]        feature_index_i,
  input  wire logic [srau_pkg::DIM_W-1:0]         dimension_i,
  input  wire logic [srau_pkg::BKT_W-1:0]         bucket_i,
  input  wire logic signed [srau_pkg::VAL_W-1:0]  write_value_i,
  output logic                                    result_valid_o,
  output logic signed [srau_pkg::VAL_W-1:0]       read_value_o
);

  localparam int unsigned VW        = srau_pkg::VAL_W;
  localparam int unsigned EW        = srau_pkg::ACC_EW;
  localparam int unsigned ROW_DEPTH = NUM_FEATURES * ACC_WIDTH;
  localparam int unsigned BW_DEPTH  = NUM_FEATURES * NUM_BUCKETS;
  localparam int unsigned RW_AW     = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int unsigned BW_AW     = (BW_DEPTH > 1) ? $clog2(BW_DEPTH) : 1;
  localparam int unsigned DIM_AW    = (ACC_WIDTH > 1) ? $clog2(ACC_WIDTH) : 1;
  localparam int unsigned BKT_AW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_BKT,
    S_DRAIN
  } state_e;

  state_e              state_q, state_d;
  logic                wb_valid_q, wb_valid_d;
  logic                wb_bkt_q, wb_bkt_d;
  logic                res_valid_q, res_valid_d;
  logic [DIM_AW-1:0]   d_q, d_d;
  logic [BKT_AW-1:0]   b_q, b_d;
  logic [RW_AW-1:0]    row_base_q, row_base_d;
  logic [BW_AW-1:0]    bw_base_q, bw_base_d;
  logic                sub_q, sub_d;
  logic [DIM_AW-1:0]   wb_didx_q;
  logic [BKT_AW-1:0]   wb_bidx_q;
  logic                rd_bkt_q, rd_bkt_d;
  logic                rd_zero_q, rd_zero_d;

  srau_pkg::req_e      req;
  logic                accept;
  logic                feat_ok, dim_ok, bkt_ok;
  logic [RW_AW-1:0]    row_base_in;
  logic [BW_AW-1:0]    bw_base_in;
  logic                acc_req_we, bacc_req_we;

  logic                row_we, row_re;
  logic [RW_AW-1:0]    row_waddr, row_raddr;
  logic [EW-1:0]       row_rdata;
  logic                bw_we, bw_re;
  logic [BW_AW-1:0]    bw_waddr, bw_raddr;
  logic [VW-1:0]       bw_rdata;
  logic                acc_we, acc_re;
  logic [DIM_AW-1:0]   acc_waddr, acc_raddr;
  logic [EW-1:0]       acc_wdata, acc_rdata;
  logic                bacc_we, bacc_re;
  logic [BKT_AW-1:0]   bacc_waddr, bacc_raddr;
  logic [VW-1:0]       bacc_wdata, bacc_rdata;

  logic [VW-1:0]       op_a, op_b, alu_res;

  // Decode the incoming transaction
  assign req         = srau_pkg::req_e'(req_type_i);
  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign feat_ok     = 32'(feature_index_i) < NUM_FEATURES;
  assign dim_ok      = 32'(dimension_i) < ACC_WIDTH;
  assign bkt_ok      = 32'(bucket_i) < NUM_BUCKETS;
  assign row_base_in = RW_AW'(32'(feature_index_i) * ACC_WIDTH);
  assign bw_base_in  = BW_AW'(32'(feature_index_i) * NUM_BUCKETS);
  assign acc_req_we  = accept && (req == srau_pkg::REQ_WR_ACC) && dim_ok;
  assign bacc_req_we = accept && (req == srau_pkg::REQ_WR_BACC) && bkt_ok;

  // Shared add/subtract unit for both accumulator widths
  assign op_a    = wb_bkt_q ? bacc_rdata : VW'(acc_rdata);
  assign op_b    = wb_bkt_q ? bw_rdata : VW'(row_rdata);
  assign alu_res = sub_q ? (op_a - op_b) : (op_a + op_b);

  // Row weight table
  assign row_we    = accept && (req == srau_pkg::REQ_WR_WEIGHT) && feat_ok && dim_ok;
  assign row_waddr = row_base_in + RW_AW'(dimension_i);
  assign row_re    = (state_q == S_ACC);
  assign row_raddr = row_base_q + RW_AW'(d_q);

  srau_ram #(.WIDTH(EW), .DEPTH(ROW_DEPTH)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (write_value_i[EW-1:0]),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  // Bucket weight table
  assign bw_we    = accept && (req == srau_pkg::REQ_WR_BWEIGHT) && feat_ok && bkt_ok;
  assign bw_waddr = bw_base_in + BW_AW'(bucket_i);
  assign bw_re    = (state_q == S_BKT);
  assign bw_raddr = bw_base_q + BW_AW'(b_q);

  srau_ram #(.WIDTH(VW), .DEPTH(BW_DEPTH)) u_bw_ram (
    .clk_i   (clk_i),
    .we_i    (bw_we),
    .waddr_i (bw_waddr),
    .wdata_i (write_value_i),
    .re_i    (bw_re),
    .raddr_i (bw_raddr),
    .rdata_o (bw_rdata)
  );

  // Accumulator vector: host writes or sequencer write-back
  assign acc_we    = acc_req_we || (wb_valid_q && !wb_bkt_q);
  assign acc_waddr = wb_valid_q ? wb_didx_q : DIM_AW'(dimension_i);
  assign acc_wdata = wb_valid_q ? alu_res[EW-1:0] : write_value_i[EW-1:0];
  assign acc_re    = (state_q == S_ACC) ||
                     (accept && (req == srau_pkg::REQ_RD_ACC) && dim_ok);
  assign acc_raddr = (state_q == S_ACC) ? d_q : DIM_AW'(dimension_i);

  srau_ram #(.WIDTH(EW), .DEPTH(ACC_WIDTH)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // Bucket accumulator
  assign bacc_we    = bacc_req_we || (wb_valid_q && wb_bkt_q);
  assign bacc_waddr = wb_valid_q ? wb_bidx_q : BKT_AW'(bucket_i);
  assign bacc_wdata = wb_valid_q ? alu_res : write_value_i;
  assign bacc_re    = (state_q == S_BKT) ||
                      (accept && (req == srau_pkg::REQ_RD_BUCKET) && bkt_ok);
  assign bacc_raddr = (state_q == S_BKT) ? b_q : BKT_AW'(bucket_i);

  srau_ram #(.WIDTH(VW), .DEPTH(NUM_BUCKETS)) u_bacc_ram (
    .clk_i   (clk_i),
    .we_i    (bacc_we),
    .waddr_i (bacc_waddr),
    .wdata_i (bacc_wdata),
    .re_i    (bacc_re),
    .raddr_i (bacc_raddr),
    .rdata_o (bacc_rdata)
  );

  // Sequencer next state: one element per cycle, accumulator then buckets, then drain
  always_comb begin
    state_d    = state_q;
    d_d        = d_q;
    b_d        = b_q;
    row_base_d = row_base_q;
    bw_base_d  = bw_base_q;
    sub_d      = sub_q;
    case (state_q)
      S_IDLE: begin
        if (accept && feat_ok &&
            (req == srau_pkg::REQ_ADD || req == srau_pkg::REQ_REMOVE)) begin
          state_d    = S_ACC;
          d_d        = '0;
          b_d        = '0;
          row_base_d = row_base_in;
          bw_base_d  = bw_base_in;
          sub_d      = (req == srau_pkg::REQ_REMOVE);
        end
      end
      S_ACC: begin
        d_d = d_q + 1'b1;
        if (d_q == DIM_AW'(ACC_WIDTH - 1)) begin
          state_d = S_BKT;
        end
      end
      S_BKT: begin
        b_d = b_q + 1'b1;
        if (b_q == BKT_AW'(NUM_BUCKETS - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Write-back stage and read result control
  assign wb_valid_d  = (state_q == S_ACC) || (state_q == S_BKT);
  assign wb_bkt_d    = (state_q == S_BKT);
  assign res_valid_d = accept &&
                       (req == srau_pkg::REQ_RD_ACC || req == srau_pkg::REQ_RD_BUCKET);
  assign rd_bkt_d    = (req == srau_pkg::REQ_RD_BUCKET);
  assign rd_zero_d   = rd_bkt_d ? !bkt_ok : !dim_ok;

  // Hold state and registered control outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wb_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wb_valid_q  <= wb_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Advance payload registers
  always_ff @(posedge clk_i) begin
    d_q        <= d_d;
    b_q        <= b_d;
    row_base_q <= row_base_d;
    bw_base_q  <= bw_base_d;
    sub_q      <= sub_d;
    wb_bkt_q   <= wb_bkt_d;
    wb_didx_q  <= d_q;
    wb_bidx_q  <= b_q;
    if (accept) begin
      rd_bkt_q  <= rd_bkt_d;
      rd_zero_q <= rd_zero_d;
    end
  end

  // Drive the result transaction
  assign result_valid_o = res_valid_q;
  assign read_value_o   = rd_zero_q ? '0 :
                          rd_bkt_q  ? bacc_rdata : VW'($signed(acc_rdata));

  `SRAU_ASSERT(a_res_after_read, result_valid_o |-> $past(start && !busy && (req_type_i == srau_pkg::REQ_RD_ACC || req_type_i == srau_pkg::REQ_RD_BUCKET)), "result strobe without an accepted read")
  `SRAU_ASSERT(a_wb_while_busy, wb_valid_q |-> busy, "write-back outside an add or remove")
  `SRAU_ASSERT_NEVER(a_acc_port_clash, acc_req_we && wb_valid_q, "host write collides with write-back")
  `SRAU_ASSERT(a_drain_after_bkt, (state_q == S_DRAIN) |-> $past(state_q == S_BKT), "drain not preceded by bucket pass")

endmodule

`default_nettype wire
